### hdl/rrsl_pkg.sv
// Shared types and codes for the relay range shift loader.
`timescale 1ns / 1ps
`default_nettype none

package rrsl_pkg;

	typedef enum logic [2:0] {
		KIND_TICK   = 3'd0,
		KIND_SELECT = 3'd1,
		KIND_CLEAR  = 3'd2,
		KIND_ARM    = 3'd3,
		KIND_POLL   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PH_START   = 2'd0,
		PH_SHIFT   = 2'd1,
		PH_STORAGE = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		RANGE_NONE  = 2'd0,
		RANGE_2V5   = 2'd1,
		RANGE_250MV = 2'd2
	} range_t;

	localparam logic [3:0] POS_LAST_DIRECT = 4'd6;
	localparam logic [3:0] POS_LOW_RANGE   = 4'd7;
	localparam logic [3:0] BC_LAST_DATA    = 4'd7;
	localparam logic [3:0] BC_FINAL_CLK    = 4'd8;
	localparam logic [3:0] BC_LATCH        = 4'd9;
	localparam logic [3:0] BC_DONE         = 4'd10;
	localparam logic [7:0] LOW_RANGE_RELAY = 8'h40;

	localparam int IN_DATA_W  = 24;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 32;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] position;
		logic [7:0] seq_byte;
		logic [7:0] origin_ctrl;
	} item_t;

	typedef struct packed {
		logic       shift_clk;
		logic       latch_clk;
		logic       serial_bit;
		logic       busy_res;
		logic       setpoint_valid;
		logic [2:0] setpoint_index;
		range_t     range_code;
		logic       bad_position;
		logic       done_valid;
		logic [7:0] done_seq;
		logic [7:0] done_ctrl;
	} res_t;

endpackage

`default_nettype wire

### hdl/relay_range_shift_loader.sv
// Top level of the relay range shift loader: request register, sequencer, result register.
//
// Usage: each request on the s_axis channel is one step of the relay driver.
// s_axis_tuser carries the kind (tick, select, clear, arm notify, poll notify);
// s_axis_tdata carries position, sequence byte and control byte. Every request
// gives exactly one result on m_axis, holding the shift clock, latch and serial
// data pin levels after the step, the busy flag, setpoint and range requests,
// the bad position flag and any released completion notification.
// A request waits in the request register; its result is registered in the result register.
// Throughput: one request per cycle while the receiver takes results; the request
// register and result register each take a new entry whenever the stage behind them moves.
// When the receiver stalls, the result register holds, then the request
// register fills and s_axis_tready drops until m_axis_tready returns.
// Reset clears both registers and puts the sequencer at start with the blanking
// pass first, no switch running, all pins low and no notification armed.
`timescale 1ns / 1ps
`default_nettype none

module relay_range_shift_loader (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// position[3:0], seq_byte[11:4], origin_ctrl[19:12], zero pad
	input  wire  [rrsl_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// kind[2:0]
	input  wire  [rrsl_pkg::IN_USER_W-1:0]      s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// shift_clk[0], latch_clk[1], serial_bit[2], busy_res[3], setpoint_valid[4],
	// setpoint_index[7:5], range_code[9:8], bad_position[10], done_valid[11],
	// done_seq[19:12], done_ctrl[27:20], zero pad
	output logic [rrsl_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

	logic            valid_s1;
	rrsl_pkg::item_t item_s1;
	logic            valid_s2;
	rrsl_pkg::res_t  res_s2;
	rrsl_pkg::res_t  res;
	logic            advance;
	logic            step;

	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign step          = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.kind        <= rrsl_pkg::kind_t'(s_axis_tuser);
			item_s1.position    <= s_axis_tdata[3:0];
			item_s1.seq_byte    <= s_axis_tdata[11:4];
			item_s1.origin_ctrl <= s_axis_tdata[19:12];
		end
		if (step) begin
			res_s2 <= res;
		end
	end

	rrsl_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.res    (res)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'b0000,
	                        res_s2.done_ctrl,
	                        res_s2.done_seq,
	                        res_s2.done_valid,
	                        res_s2.bad_position,
	                        res_s2.range_code,
	                        res_s2.setpoint_index,
	                        res_s2.setpoint_valid,
	                        res_s2.busy_res,
	                        res_s2.serial_bit,
	                        res_s2.latch_clk,
	                        res_s2.shift_clk};

`ifndef SYNTHESIS
	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("request side stalled without result stall");

	a_latch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1]) |-> (!m_axis_tdata[0] && m_axis_tdata[3]))
		else $error("latch high outside a running switch");

	a_idle_pins: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[3]) |-> (!m_axis_tdata[0] && !m_axis_tdata[1]))
		else $error("clock or latch left high while idle");

	a_done_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[11]) |-> (!m_axis_tdata[4] && !m_axis_tdata[10]))
		else $error("notification released with a setpoint result");
`endif

endmodule

`default_nettype wire

### hdl/rrsl_sequencer.sv
// Relay sequencer state and per-request next-state and result logic.
`timescale 1ns / 1ps
`default_nettype none

module rrsl_sequencer (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               step,
	input  wire rrsl_pkg::item_t item,
	output rrsl_pkg::res_t    res
);

	rrsl_pkg::phase_t phase_q, phase_d;
	logic [3:0] bit_count_q, bit_count_d;
	logic       blank_q, blank_d;
	logic       switching_q, switching_d;
	logic [7:0] pattern_q, pattern_d;
	logic [2:0] pins_q, pins_d;
	logic       pending_q, pending_d;
	logic       ready_q, ready_d;
	logic [7:0] seq_q, seq_d;
	logic [7:0] ctrl_q, ctrl_d;

	always_comb begin
		logic [7:0] pat;
		phase_d     = phase_q;
		bit_count_d = bit_count_q;
		blank_d     = blank_q;
		switching_d = switching_q;
		pattern_d   = pattern_q;
		pins_d      = pins_q;
		pending_d   = pending_q;
		ready_d     = ready_q;
		seq_d       = seq_q;
		ctrl_d      = ctrl_q;
		res                = '0;
		res.range_code     = rrsl_pkg::RANGE_NONE;
		pat = blank_q ? 8'h00 : pattern_q;

		unique case (item.kind)
			rrsl_pkg::KIND_TICK: begin
				if (switching_q) begin
					priority if (bit_count_q <= rrsl_pkg::BC_LAST_DATA) begin
						if (phase_q == rrsl_pkg::PH_SHIFT) begin
							pins_d[0] = 1'b1;
							phase_d   = rrsl_pkg::PH_STORAGE;
						end else begin
							pins_d[0] = 1'b0;
							if (phase_q != rrsl_pkg::PH_STORAGE) begin
								pins_d[1] = 1'b0;
							end
							pins_d[2]   = pat[bit_count_q[2:0]];
							bit_count_d = bit_count_q + 4'd1;
							phase_d     = rrsl_pkg::PH_SHIFT;
						end
					end else if (bit_count_q == rrsl_pkg::BC_FINAL_CLK) begin
						pins_d[0]   = 1'b1;
						bit_count_d = rrsl_pkg::BC_LATCH;
					end else if (bit_count_q == rrsl_pkg::BC_LATCH) begin
						pins_d[0]   = 1'b0;
						pins_d[1]   = 1'b1;
						bit_count_d = rrsl_pkg::BC_DONE;
					end else begin
						bit_count_d = 4'd0;
						pins_d[1]   = 1'b0;
						phase_d     = rrsl_pkg::PH_START;
						if (!blank_q) begin
							switching_d = 1'b0;
							pattern_d   = 8'h00;
							if (pending_q) begin
								ready_d = 1'b1;
							end
						end
						blank_d = !blank_q;
					end
				end
			end
			rrsl_pkg::KIND_SELECT: begin
				priority if (item.position >= 4'd1 &&
				             item.position <= rrsl_pkg::POS_LAST_DIRECT) begin
					pattern_d          = 8'h01 << item.position[2:0];
					switching_d        = 1'b1;
					res.setpoint_valid = 1'b1;
					res.setpoint_index = item.position[2:0];
					res.range_code     = rrsl_pkg::RANGE_2V5;
				end else if (item.position == rrsl_pkg::POS_LOW_RANGE) begin
					pattern_d          = rrsl_pkg::LOW_RANGE_RELAY;
					switching_d        = 1'b1;
					res.setpoint_valid = 1'b1;
					res.setpoint_index = item.position[2:0];
					res.range_code     = rrsl_pkg::RANGE_250MV;
				end else begin
					res.bad_position = 1'b1;
				end
			end
			rrsl_pkg::KIND_CLEAR: begin
				pattern_d          = 8'h00;
				switching_d        = 1'b1;
				res.setpoint_valid = 1'b1;
			end
			rrsl_pkg::KIND_ARM: begin
				pending_d = 1'b1;
				ready_d   = 1'b0;
				seq_d     = item.seq_byte;
				ctrl_d    = item.origin_ctrl;
			end
			rrsl_pkg::KIND_POLL: begin
				if (ready_q) begin
					ready_d        = 1'b0;
					pending_d      = 1'b0;
					res.done_valid = 1'b1;
					res.done_seq   = seq_q;
					res.done_ctrl  = ctrl_q;
				end
			end
			default: begin
			end
		endcase

		res.shift_clk  = pins_d[0];
		res.latch_clk  = pins_d[1];
		res.serial_bit = pins_d[2];
		res.busy_res   = switching_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= rrsl_pkg::PH_START;
			bit_count_q <= 4'd0;
			blank_q     <= 1'b1;
			switching_q <= 1'b0;
			pattern_q   <= 8'h00;
			pins_q      <= 3'b000;
			pending_q   <= 1'b0;
			ready_q     <= 1'b0;
			seq_q       <= 8'h00;
			ctrl_q      <= 8'h00;
		end else if (step) begin
			phase_q     <= phase_d;
			bit_count_q <= bit_count_d;
			blank_q     <= blank_d;
			switching_q <= switching_d;
			pattern_q   <= pattern_d;
			pins_q      <= pins_d;
			pending_q   <= pending_d;
			ready_q     <= ready_d;
			seq_q       <= seq_d;
			ctrl_q      <= ctrl_d;
		end
	end

endmodule

`default_nettype wire

### bench/tb_relay_range_shift_loader.sv
// Testbench for the relay range shift loader: stream requests checked against a shadow sequencer.
`timescale 1ns / 1ps

module tb_relay_range_shift_loader;

	localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;
	localparam int         CYCLE_LIMIT       = 200000;
	localparam int         RANDOM_REQUESTS   = 1800;

	class relay_shadow;
		rrsl_pkg::phase_t phase;
		logic [3:0]       bit_cnt;
		logic             blanking;
		logic             running;
		logic [7:0]       relays;
		logic             sclk;
		logic             lclk;
		logic             sdata;
		logic             armed;
		logic             ready;
		logic [7:0]       seq;
		logic [7:0]       ctrl;
		rrsl_pkg::res_t   results_due[$];
		int               mismatches;

		function new();
			phase      = rrsl_pkg::PH_START;
			bit_cnt    = '0;
			blanking   = 1'b1;
			running    = 1'b0;
			relays     = '0;
			sclk       = 1'b0;
			lclk       = 1'b0;
			sdata      = 1'b0;
			armed      = 1'b0;
			ready      = 1'b0;
			seq        = '0;
			ctrl       = '0;
			mismatches = 0;
		endfunction

		function void advance_pins();
			logic [7:0] pat;
			if (!running)
				return;
			pat = blanking ? 8'h00 : relays;
			if (bit_cnt <= rrsl_pkg::BC_LAST_DATA) begin
				case (phase)
					rrsl_pkg::PH_SHIFT: begin
						sclk  = 1'b1;
						phase = rrsl_pkg::PH_STORAGE;
					end
					rrsl_pkg::PH_STORAGE: begin
						sclk    = 1'b0;
						sdata   = pat[bit_cnt[2:0]];
						bit_cnt = bit_cnt + 4'd1;
						phase   = rrsl_pkg::PH_SHIFT;
					end
					default: begin
						sclk    = 1'b0;
						lclk    = 1'b0;
						sdata   = pat[bit_cnt[2:0]];
						bit_cnt = bit_cnt + 4'd1;
						phase   = rrsl_pkg::PH_SHIFT;
					end
				endcase
			end else if (bit_cnt == rrsl_pkg::BC_FINAL_CLK) begin
				sclk    = 1'b1;
				bit_cnt = rrsl_pkg::BC_LATCH;
			end else if (bit_cnt == rrsl_pkg::BC_LATCH) begin
				sclk    = 1'b0;
				lclk    = 1'b1;
				bit_cnt = rrsl_pkg::BC_DONE;
			end else begin
				bit_cnt = '0;
				lclk    = 1'b0;
				phase   = rrsl_pkg::PH_START;
				if (!blanking) begin
					running = 1'b0;
					relays  = '0;
					if (armed)
						ready = 1'b1;
				end
				blanking = !blanking;
			end
		endfunction

		function void note_request(logic [2:0] kind, logic [3:0] pos, logic [7:0] sq,
			logic [7:0] ct);
			rrsl_pkg::res_t r;
			r = '0;
			case (kind)
				rrsl_pkg::KIND_TICK: advance_pins();
				rrsl_pkg::KIND_SELECT: begin
					if (pos >= 4'd1 && pos <= rrsl_pkg::POS_LAST_DIRECT) begin
						relays           = 8'd1 << pos;
						running          = 1'b1;
						r.setpoint_valid = 1'b1;
						r.setpoint_index = pos[2:0];
						r.range_code     = rrsl_pkg::RANGE_2V5;
					end else if (pos == rrsl_pkg::POS_LOW_RANGE) begin
						relays           = rrsl_pkg::LOW_RANGE_RELAY;
						running          = 1'b1;
						r.setpoint_valid = 1'b1;
						r.setpoint_index = pos[2:0];
						r.range_code     = rrsl_pkg::RANGE_250MV;
					end else begin
						r.bad_position = 1'b1;
					end
				end
				rrsl_pkg::KIND_CLEAR: begin
					relays           = '0;
					running          = 1'b1;
					r.setpoint_valid = 1'b1;
				end
				rrsl_pkg::KIND_ARM: begin
					armed = 1'b1;
					ready = 1'b0;
					seq   = sq;
					ctrl  = ct;
				end
				rrsl_pkg::KIND_POLL: begin
					if (ready) begin
						ready       = 1'b0;
						armed       = 1'b0;
						r.done_valid = 1'b1;
						r.done_seq   = seq;
						r.done_ctrl  = ctrl;
					end
				end
				default: ;
			endcase
			r.shift_clk  = sclk;
			r.latch_clk  = lclk;
			r.serial_bit = sdata;
			r.busy_res   = running;
			results_due.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(logic [rrsl_pkg::OUT_DATA_W-1:0] d);
			rrsl_pkg::res_t e;
			if (results_due.size() == 0) begin
				$error("result with no request outstanding: %h", d);
				mismatches++;
				return;
			end
			e = results_due.pop_front();
			compare_field("shift_clk", e.shift_clk, d[0]);
			compare_field("latch_clk", e.latch_clk, d[1]);
			compare_field("serial_bit", e.serial_bit, d[2]);
			compare_field("busy_res", e.busy_res, d[3]);
			compare_field("setpoint_valid", e.setpoint_valid, d[4]);
			compare_field("setpoint_index", e.setpoint_index, d[7:5]);
			compare_field("range_code", e.range_code, d[9:8]);
			compare_field("bad_position", e.bad_position, d[10]);
			compare_field("done_valid", e.done_valid, d[11]);
			compare_field("done_seq", e.done_seq, d[19:12]);
			compare_field("done_ctrl", e.done_ctrl, d[27:20]);
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            s_axis_tvalid;
	wire                             s_axis_tready;
	logic [rrsl_pkg::IN_DATA_W-1:0]  s_axis_tdata;
	logic [rrsl_pkg::IN_USER_W-1:0]  s_axis_tuser;
	wire                             m_axis_tvalid;
	logic                            m_axis_tready;
	wire  [rrsl_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	int                              cycles = 0;
	relay_shadow                     board = new();

	relay_range_shift_loader dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("** relay_range_shift_loader: FAILED **");
			$finish;
		end
	end

	task automatic send_request(input logic [2:0] kind, input logic [3:0] pos,
		input logic [7:0] sq, input logic [7:0] ct, input int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {4'd0, ct, sq, pos};
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		board.note_request(kind, pos, sq, ct);
		@(negedge clk);
	endtask

	task automatic send_random(input int gap);
		int         pick;
		logic [2:0] kind;
		logic [3:0] pos;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 4) == 0)
			pos = 4'($urandom_range(0, 15));
		else
			pos = 4'($urandom_range(1, 7));
		if (pick < 64)
			kind = rrsl_pkg::KIND_TICK;
		else if (pick < 74)
			kind = rrsl_pkg::KIND_SELECT;
		else if (pick < 80)
			kind = rrsl_pkg::KIND_CLEAR;
		else if (pick < 86)
			kind = rrsl_pkg::KIND_ARM;
		else if (pick < 97)
			kind = rrsl_pkg::KIND_POLL;
		else
			kind = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
		send_request(kind, pos, 8'($urandom), 8'($urandom), gap);
	endtask

	initial begin : drain
		int stall;
		int taken;
		taken = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (taken == 400)
				stall = 300;
			else if ((taken / 130) % 4 == 1)
				stall = 0;
			else
				stall = $urandom_range(0, 6);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!m_axis_tvalid);
			board.check_result(m_axis_tdata);
			taken++;
			@(negedge clk);
		end
	end

	initial begin : feed
		int gap;
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_request(rrsl_pkg::KIND_TICK, 4'd0, 8'h00, 8'h00, 0);
		send_request(rrsl_pkg::KIND_POLL, 4'd0, 8'h00, 8'h00, 0);
		send_request(rrsl_pkg::KIND_SELECT, 4'd0, 8'h00, 8'h00, 1);
		send_request(rrsl_pkg::KIND_SELECT, 4'd8, 8'h00, 8'h00, 0);
		send_request(rrsl_pkg::KIND_SELECT, 4'd15, 8'hFF, 8'hFF, 0);
		send_request(KIND_UNUSED_FIRST, 4'd7, 8'hFF, 8'hFF, 2);
		send_request(KIND_UNUSED_FIRST + 3'd1, 4'd1, 8'h00, 8'h00, 0);
		send_request(KIND_UNUSED_LAST, 4'd15, 8'hFF, 8'h00, 0);
		send_request(rrsl_pkg::KIND_ARM, 4'd0, 8'h00, 8'hFF, 0);
		send_request(rrsl_pkg::KIND_ARM, 4'd15, 8'hFF, 8'h00, 1);
		send_request(rrsl_pkg::KIND_SELECT, 4'd1, 8'h00, 8'h00, 0);
		repeat (3) send_request(rrsl_pkg::KIND_TICK, 4'd0, 8'h00, 8'h00, 0);
		send_request(rrsl_pkg::KIND_SELECT, rrsl_pkg::POS_LOW_RANGE, 8'h00, 8'h00, 0);
		send_request(rrsl_pkg::KIND_CLEAR, 4'd0, 8'h00, 8'h00, 3);
		send_request(rrsl_pkg::KIND_SELECT, rrsl_pkg::POS_LAST_DIRECT, 8'h00, 8'h00, 0);
		repeat (3) send_request(rrsl_pkg::KIND_TICK, 4'd0, 8'h00, 8'h00, 0);
		send_request(rrsl_pkg::KIND_POLL, 4'd0, 8'h00, 8'h00, 0);
		send_request(rrsl_pkg::KIND_ARM, 4'd0, 8'h5A, 8'hA5, 0);

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if ((i / 150) % 4 == 2)
				gap = 0;
			else
				gap = $urandom_range(0, 6);
			send_random(gap);
		end
		s_axis_tvalid <= 1'b0;

		while (board.results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (board.mismatches == 0 && board.results_due.size() == 0)
			$display("** relay_range_shift_loader: PASSED **");
		else
			$display("** relay_range_shift_loader: FAILED **");
		$finish;
	end

endmodule

### sim.f
hdl/rrsl_pkg.sv
hdl/rrsl_sequencer.sv
hdl/relay_range_shift_loader.sv
bench/tb_relay_range_shift_loader.sv
